// ===== hw/rtl/pwk_pkg.sv =====
// shared types, constants and helpers for the page table walker
`default_nettype none

package pwk_pkg;

  localparam int TABLE_PAGES_DEF = 16;
  localparam int ENTRY_W         = 64;
  localparam int IDX_W           = 9;
  localparam int LEVELS          = 4;
  localparam int VA_W            = 48;
  localparam int PA_W            = 52;
  localparam int FLAGS_W         = 12;
  localparam int FRAME_W         = 40;

  // intermediate tables are linked present and writable
  localparam logic [FLAGS_W-1:0] LINK_FLAGS = 12'h003;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_MAPPED = 2'd1,
    ST_NO_PAGE    = 2'd2
  } status_t;

  typedef enum logic {
    OP_MAP       = 1'b0,
    OP_TRANSLATE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_OUT
  } state_t;

  // decision of the entry unit for one level
  typedef struct packed {
    logic    stop;
    logic    wr;
    logic    alloc;
    status_t status;
  } dec_t;

  // level 0 is the root: bits 47..39; level 3: bits 20..12
  function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                   input logic [1:0] lv);
    logic [IDX_W-1:0] idx;
    idx = '0;
    case (lv)
      2'd0: idx = va[47:39];
      2'd1: idx = va[38:30];
      2'd2: idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pwk_table_ram.sv =====
// single-port table store with registered read data
`default_nettype none

module pwk_table_ram #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [AW-1:0]                addr,
  input  wire logic [pwk_pkg::ENTRY_W-1:0]  wdata,
  output logic      [pwk_pkg::ENTRY_W-1:0]  rdata
);
  import pwk_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pwk_entry_unit.sv =====
// per-level entry check and update, shared by every step of the walk
`default_nettype none

module pwk_entry_unit #(
  parameter int TABLE_PAGES = 16,
  parameter int PGW         = 4,
  parameter int NFW         = 5
) (
  input  wire logic [pwk_pkg::ENTRY_W-1:0] entry,
  input  wire logic                        is_leaf,
  input  wire pwk_pkg::op_t                op,
  input  wire logic [pwk_pkg::PA_W-1:0]    pa,
  input  wire logic [pwk_pkg::FLAGS_W-1:0] flags,
  input  wire logic [11:0]                 va_off,
  input  wire logic [NFW-1:0]              nfp,
  output pwk_pkg::dec_t                    dec,
  output logic      [PGW-1:0]              next_page,
  output logic      [pwk_pkg::ENTRY_W-1:0] wdata,
  output logic      [pwk_pkg::PA_W-1:0]    phys
);
  import pwk_pkg::*;

  logic [FRAME_W-1:0] frame;
  logic               present;
  logic               link_bad;
  logic               store_full;

  assign frame      = entry[51:12];
  assign present    = entry[0];
  assign link_bad   = frame >= FRAME_W'(TABLE_PAGES);
  assign store_full = nfp >= NFW'(TABLE_PAGES);

  always_comb begin
    dec       = '{stop: 1'b0, wr: 1'b0, alloc: 1'b0, status: ST_OK};
    next_page = frame[PGW-1:0];
    wdata     = entry;
    phys      = '0;
    if (is_leaf) begin
      dec.stop = 1'b1;
      if (op == OP_MAP) begin
        dec.wr = 1'b1;
        wdata  = {entry[63:52], pa[51:12], entry[11:0] | flags};
      end else if (present) begin
        phys = {frame, va_off};
      end else begin
        dec.status = ST_NOT_MAPPED;
      end
    end else if (present) begin
      if (link_bad) begin
        dec.stop   = 1'b1;
        dec.status = (op == OP_TRANSLATE) ? ST_NOT_MAPPED : ST_NO_PAGE;
      end
    end else if (op == OP_TRANSLATE) begin
      dec.stop   = 1'b1;
      dec.status = ST_NOT_MAPPED;
    end else if (store_full) begin
      dec.stop   = 1'b1;
      dec.status = ST_NO_PAGE;
    end else begin
      // link a fresh table page, already zero from the clearing pass
      dec.wr    = 1'b1;
      dec.alloc = 1'b1;
      next_page = nfp[PGW-1:0];
      wdata     = {entry[63:52], FRAME_W'(nfp), entry[11:0] | LINK_FLAGS};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/four_level_page_table_walker.sv =====
// top level: four-level page table walker with sequencer and result register
`default_nettype none

// Four-level x86-64 style page table walker over an on-chip store of
// TABLE_PAGES table pages of 512 64-bit entries, root at page 0. After reset
// a clearing pass zeroes the store, one entry a cycle; s_tready stays low
// until it ends. A map transaction walks the levels, links fresh zero tables
// from a bump counter where a level is missing and writes the leaf, or
// returns "no page" once the store has no free table page left; a translate
// transaction returns frame plus offset or "not mapped". Each level uses the
// single table RAM port in S_READ (address out) and S_EVAL (registered entry
// back and, if needed, written back); the result is then posted from S_OUT.
// One transaction is walked at a time; a new one is taken while the previous
// result still waits in the output register. s_tready comes back in the
// cycle after the result is posted, so a transaction holds the block until
// its result is posted, which waits on m_tready while the register is full.

module four_level_page_table_walker #(
  parameter int TABLE_PAGES = pwk_pkg::TABLE_PAGES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // input channel
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [111:0] s_tdata,  // virt_addr[47:0], phys_addr[99:48], page_flags[111:100]
  input  wire logic [0:0]   s_tuser,  // operation[0]
  // result channel
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [55:0]       m_tdata,  // phys_out[51:0], zero pad[55:52]
  output logic [1:0]        m_tuser   // status[1:0]
);
  import pwk_pkg::*;

  localparam int PGW   = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int NFW   = $clog2(TABLE_PAGES + 1);
  localparam int AW    = PGW + IDX_W;
  localparam int DEPTH = TABLE_PAGES * (2 ** IDX_W);

  state_t state, state_next;

  // captured transaction
  op_t                op;
  logic [VA_W-1:0]    va;
  logic [PA_W-1:0]    pa;
  logic [FLAGS_W-1:0] flags;

  // walk state
  logic [1:0]     lv;
  logic [PGW-1:0] page;
  logic [NFW-1:0] nfp;
  logic [AW-1:0]  clr_addr;

  // pending result
  logic [PA_W-1:0] res_phys;
  status_t         res_status;

  // ram port
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  // entry unit
  dec_t               dec;
  logic [PGW-1:0]     dec_page;
  logic [ENTRY_W-1:0] dec_wdata;
  logic [PA_W-1:0]    dec_phys;

  logic accept;
  logic post;
  logic is_leaf;

  assign is_leaf = lv == 2'(LEVELS - 1);
  assign accept  = s_tvalid && s_tready;

  pwk_table_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  pwk_entry_unit #(
    .TABLE_PAGES (TABLE_PAGES),
    .PGW         (PGW),
    .NFW         (NFW)
  ) u_entry (
    .entry     (ram_rdata),
    .is_leaf   (is_leaf),
    .op        (op),
    .pa        (pa),
    .flags     (flags),
    .va_off    (va[11:0]),
    .nfp       (nfp),
    .dec       (dec),
    .next_page (dec_page),
    .wdata     (dec_wdata),
    .phys      (dec_phys)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state and ram port
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    post       = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = {page, level_index(va, lv)};
    ram_wdata  = dec_wdata;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr;
        ram_wdata = '0;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        ram_we = dec.wr;
        if (dec.stop) begin
          state_next = S_OUT;
        end else begin
          state_next = S_READ;
        end
      end
      S_OUT: begin
        // wait for the output register to free up
        if (!m_tvalid || m_tready) begin
          post       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      nfp      <= NFW'(1);
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == S_EVAL && !dec.stop && dec.alloc) begin
        nfp <= nfp + NFW'(1);
      end
      if (post) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= op_t'(s_tuser[0]);
      va    <= s_tdata[47:0];
      pa    <= s_tdata[99:48];
      flags <= s_tdata[111:100];
      lv    <= 2'd0;
      page  <= '0;
    end else if (state == S_EVAL) begin
      if (dec.stop) begin
        res_phys   <= dec_phys;
        res_status <= dec.status;
      end else begin
        lv   <= lv + 2'd1;
        page <= dec_page;
      end
    end
    if (post) begin
      m_tdata <= {4'd0, res_phys};
      m_tuser <= res_status;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the four-level page table walker
`timescale 1ns / 1ps

module testbench;
  import pwk_pkg::*;

  localparam int PAGES      = TABLE_PAGES_DEF;
  localparam int PER_TABLE  = 512;
  localparam int DRAIN_WAIT = 20;

  // one input transaction and one result transaction, in port terms
  typedef struct packed {
    op_t              op;
    logic [VA_W-1:0]  va;
    logic [PA_W-1:0]  pa;
    logic [FLAGS_W-1:0] flags;
  } walk_req_t;

  typedef struct packed {
    logic [PA_W-1:0] phys;
    status_t         status;
  } walk_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata  = '0;  // virt_addr[47:0], phys_addr[99:48], page_flags[111:100]
  logic [0:0]   s_tuser  = '0;  // operation[0]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [55:0]  m_tdata;        // phys_out[51:0], zero pad[55:52]
  logic [1:0]   m_tuser;        // status[1:0]

  four_level_page_table_walker #(.TABLE_PAGES(PAGES)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the page table and the bump allocator
  logic [ENTRY_W-1:0] shadow_pt [PAGES*PER_TABLE];
  int unsigned        shadow_next_page;

  walk_req_t    walk_reqs [$];     // transactions not yet offered to the block
  walk_result_t walk_results [$];  // expected results, oldest first
  logic [VA_W-1:0] touched_va [$]; // addresses already used, to stay inside live tables

  int errors = 0;
  int n_sent = 0, n_recv = 0, n_total = 0;
  int n_map = 0, n_xlate = 0, n_ok = 0, n_unmapped = 0, n_nopage = 0;

  // every fourth stretch of 100 transactions runs with no idle cycles at all
  logic calm;
  assign calm = ((n_sent / 100) % 4) == 3;

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // walks the shadow table exactly as the block does and updates it
  function automatic walk_result_t walk_page_table(walk_req_t req);
    walk_result_t res;
    int unsigned  page, np, idx_slot;
    logic [IDX_W-1:0]   idx;
    logic [ENTRY_W-1:0] ent;
    logic [FRAME_W-1:0] frame;
    logic               stop;
    res.phys   = '0;
    res.status = ST_OK;
    page       = 0;
    stop       = 1'b0;
    for (int lv = 0; lv < LEVELS - 1 && !stop; lv++) begin
      idx      = req.va[47 - 9*lv -: 9];
      idx_slot = page * PER_TABLE + 32'(idx);
      ent      = shadow_pt[idx_slot];
      if (ent[0]) begin
        frame = ent[51:12];
        if (frame >= FRAME_W'(PAGES)) begin
          // corrupt link: cannot happen, kept for parity with the hardware guard
          res.status = (req.op == OP_TRANSLATE) ? ST_NOT_MAPPED : ST_NO_PAGE;
          stop = 1'b1;
        end else begin
          page = 32'(frame);
        end
      end else if (req.op == OP_TRANSLATE) begin
        res.status = ST_NOT_MAPPED;
        stop = 1'b1;
      end else if (shadow_next_page >= PAGES) begin
        // store exhausted: links made above stay, no leaf written
        res.status = ST_NO_PAGE;
        stop = 1'b1;
      end else begin
        np = shadow_next_page;
        shadow_next_page++;
        for (int k = 0; k < PER_TABLE; k++) shadow_pt[np*PER_TABLE + k] = '0;
        ent[51:12] = FRAME_W'(np);
        ent[11:0]  = ent[11:0] | LINK_FLAGS;
        shadow_pt[idx_slot] = ent;
        page = np;
      end
    end
    if (res.status == ST_OK) begin
      idx_slot = page * PER_TABLE + 32'(req.va[20:12]);
      ent      = shadow_pt[idx_slot];
      if (req.op == OP_MAP) begin
        // new frame, old flags kept and new ones ORed in
        ent[51:12] = req.pa[51:12];
        ent[11:0]  = ent[11:0] | req.flags;
        shadow_pt[idx_slot] = ent;
      end else if (ent[0]) begin
        res.phys = {ent[51:12], req.va[11:0]};
      end else begin
        res.status = ST_NOT_MAPPED;
      end
    end
    return res;
  endfunction

  // random transaction, mostly near addresses already in use so walks go deep
  function automatic walk_req_t make_random_req();
    walk_req_t       req;
    logic [63:0]     rnd_va, rnd_pa;
    logic [VA_W-1:0] base;
    int              r;
    rnd_va    = {$urandom, $urandom};
    rnd_pa    = {$urandom, $urandom};
    req.op    = ($urandom_range(0, 99) < 55) ? OP_MAP : OP_TRANSLATE;
    req.pa    = rnd_pa[PA_W-1:0];
    req.flags = rnd_pa[63:52];
    if ($urandom_range(0, 99) < 80) req.flags[0] = 1'b1;
    r = $urandom_range(0, 99);
    if (touched_va.size() == 0 || r < 25) begin
      req.va = rnd_va[VA_W-1:0];
    end else begin
      base = touched_va[$urandom_range(0, touched_va.size() - 1)];
      req.va = base;
      if (r >= 45 && r < 75) req.va[20:0] = rnd_va[20:0];       // same leaf table
      else if (r >= 75 && r < 90) req.va[11:0] = rnd_va[11:0];  // same page, new offset
      else if (r >= 90) req.va[29:0] = rnd_va[29:0];            // same level-2 table
    end
    if (req.op == OP_MAP && touched_va.size() < 64) touched_va.push_back(req.va);
    return req;
  endfunction

  // driver: offers queued transactions, predicts each one as it is accepted
  int        send_gap = 0;
  walk_req_t cur_req  = '0;

  always @(posedge clk) begin : drive
    walk_req_t    nxt;
    walk_result_t want;
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        want = walk_page_table(cur_req);
        walk_results.push_back(want);
        n_sent++;
        if (cur_req.op == OP_MAP) n_map++;
        else n_xlate++;
        case (want.status)
          ST_OK:         n_ok++;
          ST_NOT_MAPPED: n_unmapped++;
          default:       n_nopage++;
        endcase
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          s_tvalid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (walk_reqs.size() > 0) begin
          nxt = walk_reqs.pop_front();
          cur_req  <= nxt;
          s_tdata  <= {nxt.flags, nxt.pa, nxt.va};
          s_tuser  <= nxt.op;
          s_tvalid <= 1'b1;
          send_gap <= calm ? 0 : pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: stalls the result channel at random and checks every result
  int recv_stall = 0;

  always @(posedge clk) begin : monitor
    walk_result_t want;
    if (rst) begin
      m_tready   <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_recv++;
        if (walk_results.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: phys_out %h status %0d",
                   $time, m_tdata, m_tuser);
        end else begin
          want = walk_results.pop_front();
          if (m_tdata !== {4'b0, want.phys}) begin
            errors++;
            $display("%0t: phys_out mismatch: expected %h actual %h",
                     $time, {4'b0, want.phys}, m_tdata);
          end
          if (m_tuser !== want.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, m_tuser);
          end
        end
      end
      if (recv_stall > 0) begin
        m_tready   <= 1'b0;
        recv_stall <= recv_stall - 1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready   <= 1'b0;
        recv_stall <= pick_gap();
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // build the stimulus, release reset, wait for the last result
  initial begin : stimulus
    walk_req_t req;
    for (int k = 0; k < PAGES*PER_TABLE; k++) shadow_pt[k] = '0;
    shadow_next_page = 1;

    // directed: first mapping, empty root, extremes, non-present leaf, remap
    walk_reqs.push_back('{OP_MAP,       48'h0000_0000_0000, 52'h0_0000_1234_5FFF, 12'h003});
    walk_reqs.push_back('{OP_TRANSLATE, 48'h0000_0000_0000, 52'h0, 12'h0});
    walk_reqs.push_back('{OP_TRANSLATE, 48'hFFFF_FFFF_FFFF, 52'h0, 12'h0});
    walk_reqs.push_back('{OP_MAP,       48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, 12'hFFF});
    walk_reqs.push_back('{OP_TRANSLATE, 48'hFFFF_FFFF_FFFF, 52'h0, 12'h0});
    walk_reqs.push_back('{OP_MAP,       48'h0000_0000_1000, 52'h0_0000_ABCD_E000, 12'h002});
    walk_reqs.push_back('{OP_TRANSLATE, 48'h0000_0000_1ABC, 52'h0, 12'h0});
    walk_reqs.push_back('{OP_MAP,       48'h0000_0000_0000, 52'h8_0000_0000_0000, 12'h010});
    walk_reqs.push_back('{OP_TRANSLATE, 48'h0000_0000_0FFF, 52'h0, 12'h0});
    walk_reqs.push_back('{OP_TRANSLATE, 48'h0000_4000_0000, 52'h0, 12'h0});  // level 1 missing
    walk_reqs.push_back('{OP_TRANSLATE, 48'h0000_0020_0000, 52'h0, 12'h0});  // level 2 missing
    walk_reqs.push_back('{OP_MAP,       48'h8000_0000_0000, 52'h0, 12'h001});
    walk_reqs.push_back('{OP_TRANSLATE, 48'h8000_0000_0123, 52'h0, 12'h0});
    touched_va.push_back(48'h0000_0000_0000);
    touched_va.push_back(48'hFFFF_FFFF_FFFF);
    touched_va.push_back(48'h0000_0000_1000);
    touched_va.push_back(48'h8000_0000_0000);

    // random part; the few free table pages run out early, then the
    // traffic keeps working inside the tables that exist
    for (int i = 0; i < 1000; i++) begin
      req = make_random_req();
      walk_reqs.push_back(req);
    end
    n_total = walk_reqs.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // every transaction has to come back as a result
    while (n_recv < n_total) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("walked %0d map and %0d translate transactions, %0d results checked",
             n_map, n_xlate, n_recv);
    $display("outcomes: %0d ok, %0d not mapped, %0d out of table pages",
             n_ok, n_unmapped, n_nopage);
    if (errors == 0 && n_recv == n_total && walk_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // covers the clearing pass and the slowest run several times over
  initial begin : watchdog
    #4_000_000;
    $display("timeout after %0t with %0d results still expected", $time, walk_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
